@@ rtl/adpu_pkg.sv @@
// ----------------------------------------------------------------------------
// adpu_pkg
// shared types, codes and helpers of the data processing unit
// ----------------------------------------------------------------------------
package adpu_pkg;

    typedef enum logic [3:0] {
        CLS_DP    = 4'd0,
        CLS_CFAIL = 4'd1,
        CLS_BX    = 4'd2,
        CLS_SWP   = 4'd3,
        CLS_MUL   = 4'd4,
        CLS_MULL  = 4'd5,
        CLS_HALF  = 4'd6,
        CLS_SDT   = 4'd7,
        CLS_BDT   = 4'd8,
        CLS_B     = 4'd9,
        CLS_BL    = 4'd10,
        CLS_CDT   = 4'd11,
        CLS_CDP   = 4'd12,
        CLS_CRT   = 4'd13,
        CLS_SWI   = 4'd14
    } t_op_class;

    localparam logic [3:0] OP_AND = 4'h0, OP_EOR = 4'h1, OP_SUB = 4'h2, OP_RSB = 4'h3,
                           OP_ADD = 4'h4, OP_ADC = 4'h5, OP_SBC = 4'h6, OP_RSC = 4'h7,
                           OP_TST = 4'h8, OP_TEQ = 4'h9, OP_CMP = 4'hA, OP_CMN = 4'hB,
                           OP_ORR = 4'hC, OP_MOV = 4'hD, OP_BIC = 4'hE, OP_MVN = 4'hF;

    localparam logic [3:0] REG_PC = 4'd15;

    // result beat between the execute stage and the output stage
    typedef struct packed {
        t_op_class   op_class;
        logic [31:0] result_value;
        logic [3:0]  dest_index;
        logic        dest_written;
        logic [3:0]  flags_now;
        logic [2:0]  cycle_estimate;
    } t_result;

    function automatic logic cond_pass(input logic [3:0] cond, input logic [3:0] f);
        logic n, z, c, v, p;
        n = f[3]; z = f[2]; c = f[1]; v = f[0];
        case (cond)
            4'h0: p = z;
            4'h1: p = !z;
            4'h2: p = c;
            4'h3: p = !c;
            4'h4: p = n;
            4'h5: p = !n;
            4'h6: p = v;
            4'h7: p = !v;
            4'h8: p = c && !z;
            4'h9: p = !c || z;
            4'hA: p = (n == v);
            4'hB: p = (n != v);
            4'hC: p = !z && (n == v);
            4'hD: p = z || (n != v);
            4'hE: p = 1'b1;
            default: p = 1'b0;
        endcase
        return p;
    endfunction

    function automatic t_op_class classify(input logic [31:0] w);
        t_op_class c;
        case (w[27:25])
            3'd0: begin
                if ((w & 32'h0FFFFFF0) == 32'h012FFF10) c = CLS_BX;
                else if ((w & 32'h0FB00FF0) == 32'h01000090) c = CLS_SWP;
                else if ((w & 32'h0F8000F0) == 32'h00800090) c = CLS_MULL;
                else if ((w & 32'h0FC000F0) == 32'h00000090) c = CLS_MUL;
                else if ((w & 32'h0E000090) == 32'h00000090)
                    c = (w[6:5] == 2'd0) ? CLS_SWP : CLS_HALF;
                else c = CLS_DP;
            end
            3'd1: c = CLS_DP;
            3'd2, 3'd3: c = CLS_SDT;
            3'd4: c = CLS_BDT;
            3'd5: c = w[24] ? CLS_BL : CLS_B;
            3'd6: c = CLS_CDT;
            default: c = w[24] ? CLS_SWI : (w[4] ? CLS_CRT : CLS_CDP);
        endcase
        return c;
    endfunction

endpackage

@@ rtl/adpu_shifter.sv @@
// ----------------------------------------------------------------------------
// adpu_shifter
// barrel shifter forming operand 2 and the shifter carry out
// ----------------------------------------------------------------------------
module adpu_shifter (
    input  logic [31:0] i_instr,
    input  logic [31:0] i_rm,
    input  logic [31:0] i_rs,
    input  logic        i_cin,
    output logic [31:0] o_op2,
    output logic        o_cout
);
    import adpu_pkg::*;

    logic [1:0]  typ;
    logic [7:0]  amt;
    logic [4:0]  rot;
    logic [63:0] dbl;
    logic [31:0] v;
    logic [31:0] ror_v;
    logic [31:0] lsl_v;
    logic [31:0] lsr_v;
    logic [31:0] asr_v;
    logic [4:0]  a5;
    logic [63:0] imm_d;
    logic [31:0] imm_r;

    assign typ = i_instr[6:5];
    assign v   = i_rm;
    assign amt = i_instr[4] ? i_rs[7:0] : {3'd0, i_instr[11:7]};
    assign a5  = amt[4:0];
    assign dbl = {v, v} >> a5;
    assign ror_v = dbl[31:0];
    assign lsl_v = v << a5;
    assign lsr_v = v >> a5;
    assign asr_v = $unsigned($signed(v) >>> a5);
    assign rot   = {i_instr[11:8], 1'b0};
    assign imm_d = {24'd0, i_instr[7:0], 24'd0, i_instr[7:0]} >> rot;
    assign imm_r = imm_d[31:0];

    // lsl carry is bit 32 - amount, taken modulo 32
    always_comb begin
        o_op2  = v;
        o_cout = i_cin;
        if (i_instr[25]) begin
            o_op2 = imm_r;
            if (rot != 5'd0) o_cout = imm_r[31];
        end else if (i_instr[4]) begin
            if (amt != 8'd0) begin
                case (typ)
                    2'd0: begin
                        if (amt < 8'd32) begin
                            o_op2 = lsl_v; o_cout = v[5'd0 - a5];
                        end else begin
                            o_op2 = '0; o_cout = (amt == 8'd32) ? v[0] : 1'b0;
                        end
                    end
                    2'd1: begin
                        if (amt < 8'd32) begin
                            o_op2 = lsr_v; o_cout = v[a5 - 5'd1];
                        end else begin
                            o_op2 = '0; o_cout = (amt == 8'd32) ? v[31] : 1'b0;
                        end
                    end
                    2'd2: begin
                        if (amt < 8'd32) begin
                            o_op2 = asr_v; o_cout = v[a5 - 5'd1];
                        end else begin
                            o_op2 = {32{v[31]}}; o_cout = v[31];
                        end
                    end
                    default: begin
                        if (a5 == 5'd0) o_cout = v[31];
                        else begin
                            o_op2 = ror_v; o_cout = v[a5 - 5'd1];
                        end
                    end
                endcase
            end
        end else begin
            case (typ)
                2'd0: begin
                    if (a5 != 5'd0) begin
                        o_op2 = lsl_v; o_cout = v[5'd0 - a5];
                    end
                end
                2'd1: begin
                    if (a5 == 5'd0) begin
                        o_op2 = '0; o_cout = v[31];
                    end else begin
                        o_op2 = lsr_v; o_cout = v[a5 - 5'd1];
                    end
                end
                2'd2: begin
                    if (a5 == 5'd0) begin
                        o_op2 = {32{v[31]}}; o_cout = v[31];
                    end else begin
                        o_op2 = asr_v; o_cout = v[a5 - 5'd1];
                    end
                end
                default: begin
                    if (a5 == 5'd0) begin
                        o_op2 = {i_cin, v[31:1]}; o_cout = v[0];
                    end else begin
                        o_op2 = ror_v; o_cout = v[a5 - 5'd1];
                    end
                end
            endcase
        end
    end
endmodule

@@ rtl/adpu_alu.sv @@
// ----------------------------------------------------------------------------
// adpu_alu
// sixteen data processing operations with carry and overflow
// ----------------------------------------------------------------------------
module adpu_alu (
    input  logic [3:0]  i_op,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    input  logic        i_cf,
    input  logic        i_vf,
    input  logic        i_sc,
    output logic [31:0] o_res,
    output logic        o_c,
    output logic        o_v
);
    import adpu_pkg::*;

    logic [31:0] x, y, r;
    logic        ci, arith;
    logic [32:0] s;

    always_comb begin
        arith = 1'b1;
        x = i_a; y = i_b; ci = 1'b0;
        case (i_op)
            OP_SUB, OP_CMP: begin y = ~i_b; ci = 1'b1; end
            OP_RSB: begin x = i_b; y = ~i_a; ci = 1'b1; end
            OP_ADD, OP_CMN: ci = 1'b0;
            OP_ADC: ci = i_cf;
            OP_SBC: begin y = ~i_b; ci = i_cf; end
            OP_RSC: begin x = i_b; y = ~i_a; ci = i_cf; end
            default: arith = 1'b0;
        endcase
    end

    assign s = {1'b0, x} + {1'b0, y} + {32'd0, ci};
    assign r = s[31:0];

    always_comb begin
        case (i_op)
            OP_AND, OP_TST: o_res = i_a & i_b;
            OP_EOR, OP_TEQ: o_res = i_a ^ i_b;
            OP_ORR:         o_res = i_a | i_b;
            OP_MOV:         o_res = i_b;
            OP_BIC:         o_res = i_a & ~i_b;
            OP_MVN:         o_res = ~i_b;
            default:        o_res = r;
        endcase
        o_c = arith ? s[32] : i_sc;
        o_v = arith ? (((x ^ r) & (y ^ r)) >> 31) != 32'd0 : i_vf;
    end
endmodule

@@ rtl/arm_data_processing_unit.sv @@
// ----------------------------------------------------------------------------
// arm_data_processing_unit
// ARMv4 data processing execute unit with barrel shifter
// ----------------------------------------------------------------------------
// One instruction per cycle unless stalled; the result beat is registered
// and appears in the cycle after acceptance. The sixteen registers live in
// flip-flops read at three ports in the execute cycle and written back at
// its end, so a following instruction always sees the previous write; flags
// likewise. Output is a single register stage that accepts a new beat when
// empty or being taken. Reset clears all registers and flags, no sweep needed.
module arm_data_processing_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_instr_word,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_op_class,
    output logic [31:0] o_result_value,
    output logic [3:0]  o_dest_index,
    output logic        o_dest_written,
    output logic [3:0]  o_flags_now,
    output logic [2:0]  o_cycle_estimate
);
    import adpu_pkg::*;

    logic [31:0] r_regs [16];
    logic [3:0]  r_flags;
    logic        r_valid;
    t_result     r_out, n_out;

    logic        acc;
    logic [31:0] w;
    logic        regshift;
    logic [31:0] ahead;
    logic [31:0] rn, rm, rs;
    logic [31:0] op2, res;
    logic        sc, c, v;
    logic        pass, is_dp, wr;
    logic [3:0]  op, rd;
    logic [3:0]  n_flags;
    t_op_class   cls;

    assign o_stall = r_valid && i_stall;
    assign acc = i_valid && !o_stall;
    assign w   = i_instr_word;

    assign regshift = !w[25] && w[4];
    assign ahead = regshift ? 32'd12 : 32'd8;
    assign rn = (w[19:16] == REG_PC) ? r_regs[REG_PC] + ahead : r_regs[w[19:16]];
    assign rm = (w[3:0] == REG_PC) ? r_regs[REG_PC] + ahead : r_regs[w[3:0]];
    assign rs = (w[11:8] == REG_PC) ? r_regs[REG_PC] + ahead : r_regs[w[11:8]];
    assign op = w[24:21];
    assign rd = w[15:12];

    adpu_shifter u_shifter (
        .i_instr (w),
        .i_rm    (rm),
        .i_rs    (rs),
        .i_cin   (r_flags[1]),
        .o_op2   (op2),
        .o_cout  (sc)
    );

    adpu_alu u_alu (
        .i_op  (op),
        .i_a   (rn),
        .i_b   (op2),
        .i_cf  (r_flags[1]),
        .i_vf  (r_flags[0]),
        .i_sc  (sc),
        .o_res (res),
        .o_c   (c),
        .o_v   (v)
    );

    always_comb begin
        pass  = cond_pass(w[31:28], r_flags);
        cls   = pass ? classify(w) : CLS_CFAIL;
        is_dp = (cls == CLS_DP);
        wr    = is_dp && !(op inside {OP_TST, OP_TEQ, OP_CMP, OP_CMN});
        n_flags = r_flags;
        if (is_dp && w[20]) n_flags = {res[31], res == 32'd0, c, v};
        n_out.op_class       = cls;
        n_out.result_value   = is_dp ? res : 32'd0;
        n_out.dest_index     = rd;
        n_out.dest_written   = wr;
        n_out.flags_now      = n_flags;
        n_out.cycle_estimate = 3'd1 + ((is_dp && regshift) ? 3'd1 : 3'd0)
                               + ((wr && rd == REG_PC) ? 3'd3 : 3'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_flags <= '0;
            for (int i = 0; i < 16; i++) r_regs[i] <= '0;
        end else begin
            if (acc) begin
                r_valid <= 1'b1;
                r_flags <= n_flags;
                if (wr) r_regs[rd] <= res;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) r_out <= n_out;
    end

    assign o_valid          = r_valid;
    assign o_op_class       = r_out.op_class;
    assign o_result_value   = r_out.result_value;
    assign o_dest_index     = r_out.dest_index;
    assign o_dest_written   = r_out.dest_written;
    assign o_flags_now      = r_out.flags_now;
    assign o_cycle_estimate = r_out.cycle_estimate;
endmodule
